// File: hdl/bls_pkg.sv
// Shared types and constants of the one-wire backlight level sender.
package bls_pkg;

   localparam int LEVEL_WIDTH    = 8;
   localparam int DURATION_WIDTH = 17;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LEVEL_WIDTH-1:0] MAX_LEVEL = 8'd32;
   localparam logic [7:0] DATA_MASK = 8'h1F;

   localparam logic [7:0] CYCLES_PER_US_RESET  = 8'd1;
   localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'h72;

   // opcodes of an input item
   localparam logic OPC_TICK    = 1'b0;
   localparam logic OPC_REQUEST = 1'b1;

   // register indexes of the configuration port
   localparam logic CSR_CYCLES_PER_US  = 1'b0;
   localparam logic CSR_DEVICE_ADDRESS = 1'b1;

   // waveform timings in microseconds
   localparam logic [DURATION_WIDTH-1:0] DUR_OFF_HOLD  = 17'd3000;
   localparam logic [DURATION_WIDTH-1:0] DUR_MODE_WAIT = 17'd100000;
   localparam logic [DURATION_WIDTH-1:0] DUR_MS_HIGH1  = 17'd120;
   localparam logic [DURATION_WIDTH-1:0] DUR_MS_LOW    = 17'd280;
   localparam logic [DURATION_WIDTH-1:0] DUR_MS_HIGH2  = 17'd650;
   localparam logic [DURATION_WIDTH-1:0] DUR_SHORT     = 17'd10;
   localparam logic [DURATION_WIDTH-1:0] DUR_LONG      = 17'd180;

   // classified item passed from the front end to the sequencer
   typedef struct packed {
      logic       opcode;
      logic       power_on;
      logic       level_zero;
      logic [7:0] data_byte;
   } bls_item_type;

   // queue status seen by the top level
   typedef struct packed {
      logic                       empty;
      logic                       full;
      logic [QUEUE_CNT_WIDTH-1:0] count;
   } bls_qstat_type;

endpackage

// File: hdl/bls_req_if.sv
// Request channel: opcode, level and power state with valid/ready.
interface bls_req_if;
   logic                           valid;
   logic                           ready;
   logic                           opcode;
   logic [bls_pkg::LEVEL_WIDTH-1:0] level;
   logic                           power_on;

   modport source (output valid, output opcode, output level, output power_on, input ready);
   modport sink   (input valid, input opcode, input level, input power_on, output ready);
endinterface

// File: hdl/bls_rsp_if.sv
// Result channel: line level, busy and accepted flags with valid/ready.
interface bls_rsp_if;
   logic valid;
   logic ready;
   logic line_out;
   logic busy_res;
   logic accepted;

   modport source (output valid, output line_out, output busy_res, output accepted, input ready);
   modport sink   (input valid, input line_out, input busy_res, input accepted, output ready);
endinterface

// File: hdl/bls_csr_if.sv
// Configuration write channel: register index and data with valid/ready.
interface bls_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/bls_front.sv
// Front end: takes request-channel transfers and classifies them for the queue.
module bls_front (
   bls_req_if.sink               req_ch,
   input  logic                  queue_full,
   output logic                  push,
   output bls_pkg::bls_item_type item
);

   logic [bls_pkg::LEVEL_WIDTH-1:0] level_sat;

   assign req_ch.ready = ~queue_full;
   assign push         = req_ch.valid & ~queue_full;

   // saturate, then data byte is (level - 1) masked to five bits
   assign level_sat = (req_ch.level > bls_pkg::MAX_LEVEL) ? bls_pkg::MAX_LEVEL : req_ch.level;

   always_comb begin
      item.opcode     = req_ch.opcode;
      item.power_on   = req_ch.power_on;
      item.level_zero = (level_sat == '0);
      item.data_byte  = (level_sat - 8'd1) & bls_pkg::DATA_MASK;
   end

endmodule

// File: hdl/bls_queue.sv
// Short FIFO of classified items between the front end and the sequencer.
module bls_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bls_pkg::bls_item_type  push_item,
   input  logic                   pop,
   output logic                   head_valid,
   output bls_pkg::bls_item_type  head_item,
   output bls_pkg::bls_qstat_type status
);

   bls_pkg::bls_item_type                mem_ff [bls_pkg::QUEUE_DEPTH];
   logic [bls_pkg::QUEUE_PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [bls_pkg::QUEUE_PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [bls_pkg::QUEUE_CNT_WIDTH-1:0]  count_ff, count_in;

   localparam logic [bls_pkg::QUEUE_PTR_WIDTH-1:0] LAST_PTR =
      bls_pkg::QUEUE_PTR_WIDTH'(bls_pkg::QUEUE_DEPTH - 1);
   localparam logic [bls_pkg::QUEUE_CNT_WIDTH-1:0] FULL_COUNT =
      bls_pkg::QUEUE_CNT_WIDTH'(bls_pkg::QUEUE_DEPTH);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_item;
   end

   assign head_valid   = (count_ff != '0);
   assign head_item    = mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_COUNT);
   assign status.count = count_ff;

endmodule

// File: hdl/bls_back.sv
// Sequencer: waveform state machine, timing counters, settings and result register.
module bls_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  bls_pkg::bls_item_type item,
   output logic                  pop,
   bls_csr_if.sink               csr_ch,
   bls_rsp_if.source             rsp_ch
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_OFF_HOLD, PH_MODE_WAIT, PH_MS_HIGH1, PH_MS_LOW,
      PH_MS_HIGH2, PH_START, PH_BIT_LOW, PH_BIT_HIGH, PH_STOP
   } phase_type;

   phase_type                            phase_ff, phase_in;
   logic [bls_pkg::DURATION_WIDTH-1:0]   dur_ff, dur_in;
   logic [7:0]                           prescale_ff, prescale_in;
   logic [7:0]                           shift_ff, shift_in;
   logic [2:0]                           bit_idx_ff, bit_idx_in;
   logic                                 sending_data_ff, sending_data_in;
   logic [7:0]                           data_byte_ff, data_byte_in;
   logic                                 mode_sel_ff, mode_sel_in;
   logic                                 line_ff, line_in;
   logic                                 accepted_in;
   logic [7:0]                           cycles_per_us_ff, address_ff;
   logic                                 rsp_valid_ff, rsp_line_ff, rsp_busy_ff, rsp_acc_ff;
   logic                                 step;

   assign step         = item_valid & (~rsp_valid_ff | rsp_ch.ready);
   assign pop          = step;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      logic [7:0]                         pc;
      logic [7:0]                         limit;
      logic [7:0]                         sh;
      logic [2:0]                         idx;
      logic [bls_pkg::DURATION_WIDTH-1:0] dec;

      phase_in        = phase_ff;
      dur_in          = dur_ff;
      prescale_in     = prescale_ff;
      shift_in        = shift_ff;
      bit_idx_in      = bit_idx_ff;
      sending_data_in = sending_data_ff;
      data_byte_in    = data_byte_ff;
      mode_sel_in     = mode_sel_ff;
      line_in         = line_ff;
      accepted_in     = 1'b0;

      pc    = prescale_ff + 8'd1;
      limit = (cycles_per_us_ff == '0) ? 8'd1 : cycles_per_us_ff;
      sh    = {shift_ff[6:0], 1'b0};
      idx   = bit_idx_ff + 3'd1;
      dec   = (dur_ff == '0) ? '0 : dur_ff - 1'b1;

      if (item.opcode == bls_pkg::OPC_TICK) begin
         if (phase_ff != PH_IDLE) begin
            if (pc < limit && pc != '0) begin
               prescale_in = pc;
            end else begin
               prescale_in = '0;
               dur_in      = dec;
               if (dec == '0) begin
                  case (phase_ff)
                     PH_OFF_HOLD: begin
                        phase_in = PH_IDLE;
                        dur_in   = '0;
                     end
                     PH_MODE_WAIT: begin
                        phase_in = PH_MS_HIGH1;
                        line_in  = 1'b1;
                        dur_in   = bls_pkg::DUR_MS_HIGH1;
                     end
                     PH_MS_HIGH1: begin
                        phase_in = PH_MS_LOW;
                        line_in  = 1'b0;
                        dur_in   = bls_pkg::DUR_MS_LOW;
                     end
                     PH_MS_LOW: begin
                        phase_in = PH_MS_HIGH2;
                        line_in  = 1'b1;
                        dur_in   = bls_pkg::DUR_MS_HIGH2;
                     end
                     PH_MS_HIGH2: begin
                        sending_data_in = 1'b0;
                        shift_in        = address_ff;
                        bit_idx_in      = '0;
                        phase_in        = PH_START;
                        line_in         = 1'b1;
                        dur_in          = bls_pkg::DUR_SHORT;
                     end
                     PH_START: begin
                        phase_in = PH_BIT_LOW;
                        line_in  = 1'b0;
                        dur_in   = shift_ff[7] ? bls_pkg::DUR_SHORT : bls_pkg::DUR_LONG;
                     end
                     PH_BIT_LOW: begin
                        phase_in = PH_BIT_HIGH;
                        line_in  = 1'b1;
                        dur_in   = shift_ff[7] ? bls_pkg::DUR_LONG : bls_pkg::DUR_SHORT;
                     end
                     PH_BIT_HIGH: begin
                        shift_in   = sh;
                        bit_idx_in = idx;
                        line_in    = 1'b0;
                        if (idx == '0) begin
                           phase_in = PH_STOP;
                           dur_in   = bls_pkg::DUR_SHORT;
                        end else begin
                           phase_in = PH_BIT_LOW;
                           dur_in   = sh[7] ? bls_pkg::DUR_SHORT : bls_pkg::DUR_LONG;
                        end
                     end
                     PH_STOP: begin
                        line_in = 1'b1;
                        if (!sending_data_ff) begin
                           sending_data_in = 1'b1;
                           shift_in        = data_byte_ff;
                           bit_idx_in      = '0;
                           phase_in        = PH_START;
                           dur_in          = bls_pkg::DUR_SHORT;
                        end else begin
                           phase_in = PH_IDLE;
                           dur_in   = '0;
                        end
                     end
                     default: begin
                        phase_in = PH_IDLE;
                        dur_in   = '0;
                     end
                  endcase
               end
            end
         end
      end else if (phase_ff == PH_IDLE) begin
         accepted_in = 1'b1;
         if (!item.power_on) begin
            line_in = 1'b0;
         end else begin
            prescale_in = '0;
            if (item.level_zero) begin
               mode_sel_in = 1'b0;
               phase_in    = PH_OFF_HOLD;
               line_in     = 1'b0;
               dur_in      = bls_pkg::DUR_OFF_HOLD;
            end else begin
               data_byte_in    = item.data_byte;
               sending_data_in = 1'b0;
               if (!mode_sel_ff) begin
                  mode_sel_in = 1'b1;
                  phase_in    = PH_MODE_WAIT;
                  dur_in      = bls_pkg::DUR_MODE_WAIT;
               end else begin
                  shift_in   = address_ff;
                  bit_idx_in = '0;
                  phase_in   = PH_START;
                  line_in    = 1'b1;
                  dur_in     = bls_pkg::DUR_SHORT;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         dur_ff           <= '0;
         prescale_ff      <= '0;
         shift_ff         <= '0;
         bit_idx_ff       <= '0;
         sending_data_ff  <= 1'b0;
         data_byte_ff     <= '0;
         mode_sel_ff      <= 1'b1;
         line_ff          <= 1'b1;
         cycles_per_us_ff <= bls_pkg::CYCLES_PER_US_RESET;
         address_ff       <= bls_pkg::DEVICE_ADDRESS_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (step) begin
            phase_ff        <= phase_in;
            dur_ff          <= dur_in;
            prescale_ff     <= prescale_in;
            shift_ff        <= shift_in;
            bit_idx_ff      <= bit_idx_in;
            sending_data_ff <= sending_data_in;
            data_byte_ff    <= data_byte_in;
            mode_sel_ff     <= mode_sel_in;
            line_ff         <= line_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff    <= 1'b0;
         end
         if (csr_ch.valid) begin
            case (csr_ch.index)
               bls_pkg::CSR_CYCLES_PER_US:  cycles_per_us_ff <= csr_ch.data;
               bls_pkg::CSR_DEVICE_ADDRESS: address_ff       <= csr_ch.data;
               default: ;
            endcase
         end
      end
      if (step) begin
         rsp_line_ff <= line_in;
         rsp_busy_ff <= (phase_in != PH_IDLE);
         rsp_acc_ff  <= accepted_in;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.line_out = rsp_line_ff;
   assign rsp_ch.busy_res = rsp_busy_ff;
   assign rsp_ch.accepted = rsp_acc_ff;

endmodule

// File: hdl/one_wire_backlight_level_sender.sv
// Top level of the one-wire backlight level sender.
//
// Channels: req_ch carries one item per transfer, either a tick (one step of the
// microsecond prescaler) or a brightness request with level and power state. rsp_ch
// returns exactly one result per item: line level, busy flag and whether a
// request was taken. csr_ch writes the two settings (clock cycles per
// microsecond, device address); it is always ready. It must be written only
// with no item in flight; the block itself does not enforce this.
//
// Throughput: one item per clock cycle while the output register is free or
// being read. The front end classifies the item into a two-entry queue; the
// sequencer takes one queued item each such cycle and updates its state
// machine in that same cycle. With the queue empty, a req_ch item is registered
// in the queue and then in the output register before rsp_ch valid rises.
//
// Stalls: a stalled result holds in the output register while the queue keeps
// taking items; req_ch.ready drops only once both queue entries are full.
// Reset (synchronous): idle, line high, mode flag set, settings back to
// defaults, queue and output register empty.
module one_wire_backlight_level_sender (
   input  logic       clock,
   input  logic       reset,
   bls_req_if.sink    req_ch,
   bls_rsp_if.source  rsp_ch,
   bls_csr_if.sink    csr_ch
);

   bls_pkg::bls_item_type  front_item;
   bls_pkg::bls_item_type  head_item;
   bls_pkg::bls_qstat_type q_status;
   logic                   push;
   logic                   pop;
   logic                   head_valid;

   // front end: classify and push
   bls_front u_front (
      .req_ch     (req_ch),
      .queue_full (q_status.full),
      .push       (push),
      .item       (front_item)
   );

   // decoupling queue
   bls_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (front_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .status     (q_status)
   );

   // sequencer, settings and result register
   bls_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (head_valid),
      .item       (head_item),
      .pop        (pop),
      .csr_ch     (csr_ch),
      .rsp_ch     (rsp_ch)
   );

   // a taken request that leaves the block idle can only be a power-off request
   a_idle_accept_low: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.accepted && !rsp_ch.busy_res |-> !rsp_ch.line_out)
      else $error("idle accepted result with line high");

   // no result is pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result valid after reset");

   // queue fill moves by at most one entry per cycle
   a_queue_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (q_status.count == $past(q_status.count)) ||
                        (q_status.count == $past(q_status.count) + 2'd1) ||
                        (q_status.count + 2'd1 == $past(q_status.count)))
      else $error("queue count jumped");

   // an item in the queue is drained whenever the output register is free
   a_drain: assert property (@(posedge clock) disable iff (reset)
      !q_status.empty && !rsp_ch.valid |-> pop)
      else $error("queued item not drained");

endmodule

// File: verif/tb_top.sv
// Self-checking testbench of the one-wire backlight level sender.
module tb_top;

   // ----------------------------------------------------------------------
   // Run length and idling
   // ----------------------------------------------------------------------
   localparam int ITEM_BUDGET     = 1650;        // req transfers in the whole run
   localparam int BYTE_RUN_ITEMS  = 1560;        // through the address byte
   localparam int HOLD_OFF_CYCLES = 120;         // long receiver hold-off
   localparam int HOLD_OFF_BURST  = 80;          // items offered back to back meanwhile
   localparam int SETTLE_CYCLES   = 8;           // idle margin after the last result
   localparam int CYCLE_LIMIT     = 1_000_000;   // watchdog
   localparam int MAX_REPORTS     = 10;

   // waveform phases of the line sequencer, as the predictor tracks them
   typedef enum logic [3:0] {
      WAVE_IDLE,
      WAVE_OFF_HOLD,
      WAVE_MODE_WAIT,
      WAVE_MS_HIGH1,
      WAVE_MS_LOW,
      WAVE_MS_HIGH2,
      WAVE_START,
      WAVE_BIT_LOW,
      WAVE_BIT_HIGH,
      WAVE_STOP
   } wave_phase_type;

   typedef struct packed {
      logic                            opcode;
      logic [bls_pkg::LEVEL_WIDTH-1:0] level;
      logic                            power_on;
   } bl_item_type;

   typedef struct packed {
      logic line_out;
      logic busy_res;
      logic accepted;
   } line_state_type;

   // ----------------------------------------------------------------------
   // Line predictor and store of expected line states.
   // note_input runs the waveform sequencer one item ahead; check_line
   // compares every rsp transfer against the oldest prediction.
   // ----------------------------------------------------------------------
   class line_scoreboard;
      logic [7:0]                         cycles_per_us;
      logic [7:0]                         dev_address;
      wave_phase_type                     phase;
      logic [bls_pkg::DURATION_WIDTH-1:0] us_left;
      logic [7:0]                         prescale;
      logic [7:0]                         shifter;
      logic [2:0]                         bit_cnt;
      logic                               on_data_byte;
      logic [7:0]                         data_val;
      logic                               mode_set;
      logic                               line;
      line_state_type                     awaiting[$];
      int                                 mismatches;
      int                                 unexpected;
      int                                 reported;
      int                                 checked;

      function new();
         cycles_per_us = bls_pkg::CYCLES_PER_US_RESET;
         dev_address   = bls_pkg::DEVICE_ADDRESS_RESET;
         phase         = WAVE_IDLE;
         us_left       = '0;
         prescale      = '0;
         shifter       = '0;
         bit_cnt       = '0;
         on_data_byte  = 1'b0;
         data_val      = '0;
         mode_set      = 1'b1;
         line          = 1'b1;
         mismatches    = 0;
         unexpected    = 0;
         reported      = 0;
         checked       = 0;
      endfunction

      function void write_setting(input logic idx, input logic [7:0] val);
         if (idx == bls_pkg::CSR_CYCLES_PER_US)
            cycles_per_us = val;
         else
            dev_address = val;
      endfunction

      function bit is_idle();
         return phase == WAVE_IDLE;
      endfunction

      function int pending();
         return awaiting.size();
      endfunction

      function int failures();
         return mismatches + unexpected + awaiting.size();
      endfunction

      function void go_to(input wave_phase_type ph, input logic lvl,
                          input logic [bls_pkg::DURATION_WIDTH-1:0] dur);
         phase   = ph;
         line    = lvl;
         us_left = dur;
      endfunction

      function void load_byte(input logic [7:0] val);
         shifter = val;
         bit_cnt = '0;
         go_to(WAVE_START, 1'b1, bls_pkg::DUR_SHORT);
      endfunction

      // a one is a short low and a long high, a zero the other way round
      function void step_waveform();
         logic one;
         one = shifter[7];
         case (phase)
            WAVE_OFF_HOLD:  go_to(WAVE_IDLE, line, '0);
            WAVE_MODE_WAIT: go_to(WAVE_MS_HIGH1, 1'b1, bls_pkg::DUR_MS_HIGH1);
            WAVE_MS_HIGH1:  go_to(WAVE_MS_LOW, 1'b0, bls_pkg::DUR_MS_LOW);
            WAVE_MS_LOW:    go_to(WAVE_MS_HIGH2, 1'b1, bls_pkg::DUR_MS_HIGH2);
            WAVE_MS_HIGH2: begin
               on_data_byte = 1'b0;
               load_byte(dev_address);
            end
            WAVE_START:     go_to(WAVE_BIT_LOW, 1'b0,
                                  one ? bls_pkg::DUR_SHORT : bls_pkg::DUR_LONG);
            WAVE_BIT_LOW:   go_to(WAVE_BIT_HIGH, 1'b1,
                                  one ? bls_pkg::DUR_LONG : bls_pkg::DUR_SHORT);
            WAVE_BIT_HIGH: begin
               shifter = shifter << 1;
               bit_cnt = bit_cnt + 3'd1;
               if (bit_cnt == 3'd0)
                  go_to(WAVE_STOP, 1'b0, bls_pkg::DUR_SHORT);
               else
                  go_to(WAVE_BIT_LOW, 1'b0,
                        shifter[7] ? bls_pkg::DUR_SHORT : bls_pkg::DUR_LONG);
            end
            WAVE_STOP: begin
               if (!on_data_byte) begin
                  on_data_byte = 1'b1;
                  load_byte(data_val);
               end else begin
                  go_to(WAVE_IDLE, 1'b1, '0);
               end
            end
            default:        go_to(WAVE_IDLE, line, '0);
         endcase
      endfunction

      // one microsecond passes every cycles_per_us ticks; nothing moves while idle
      function void advance_tick();
         logic [7:0] limit;
         limit = (cycles_per_us == 8'd0) ? 8'd1 : cycles_per_us;
         if (phase == WAVE_IDLE)
            return;
         prescale = prescale + 8'd1;
         if (prescale < limit && prescale != 8'd0)
            return;
         prescale = '0;
         if (us_left != '0)
            us_left = us_left - 1'b1;
         if (us_left == '0)
            step_waveform();
      endfunction

      function void note_input(input bl_item_type item);
         logic [7:0] lvl;
         logic       taken;
         taken = 1'b0;
         if (item.opcode == bls_pkg::OPC_TICK) begin
            advance_tick();
         end else if (phase == WAVE_IDLE) begin
            taken = 1'b1;
            if (!item.power_on) begin
               line = 1'b0;
            end else begin
               lvl      = (item.level > bls_pkg::MAX_LEVEL) ? bls_pkg::MAX_LEVEL
                                                            : item.level;
               prescale = '0;
               if (lvl == 8'd0) begin
                  mode_set = 1'b0;
                  go_to(WAVE_OFF_HOLD, 1'b0, bls_pkg::DUR_OFF_HOLD);
               end else begin
                  data_val     = (lvl - 8'd1) & bls_pkg::DATA_MASK;
                  on_data_byte = 1'b0;
                  if (!mode_set) begin
                     // mode flag flips when the request is taken
                     mode_set = 1'b1;
                     go_to(WAVE_MODE_WAIT, line, bls_pkg::DUR_MODE_WAIT);
                  end else begin
                     load_byte(dev_address);
                  end
               end
            end
         end
         awaiting.push_back('{line, phase != WAVE_IDLE, taken});
      endfunction

      function void check_line(input logic line_out, input logic busy_res,
                               input logic accepted);
         line_state_type want;
         checked++;
         if (awaiting.size() == 0) begin
            unexpected++;
            if (reported < MAX_REPORTS) begin
               reported++;
               $display("result %0d arrived with nothing expected: line %b busy %b accepted %b",
                        checked, line_out, busy_res, accepted);
            end
            return;
         end
         want = awaiting.pop_front();
         if (want.line_out !== line_out || want.busy_res !== busy_res ||
             want.accepted !== accepted) begin
            mismatches++;
            if (reported < MAX_REPORTS) begin
               reported++;
               $display("result %0d mismatch: expected line %b busy %b accepted %b, got line %b busy %b accepted %b",
                        checked, want.line_out, want.busy_res, want.accepted,
                        line_out, busy_res, accepted);
            end
         end
      endfunction
   endclass

   // ----------------------------------------------------------------------
   // Clock, reset, channels and the block
   // ----------------------------------------------------------------------
   logic clock;
   logic reset;

   bls_req_if req_bus ();
   bls_rsp_if rsp_bus ();
   bls_csr_if csr_bus ();

   one_wire_backlight_level_sender i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   line_scoreboard sb = new();

   int          items_sent    = 0;  // req transfers so far
   int          burst_left    = 0;  // sender items still to offer without a gap
   int          src_stretch   = 0;  // items left in the current sender stretch
   bit          src_gaps_on   = 1'b0;
   bit          hold_off_pending = 1'b0;
   int unsigned cycle_count   = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap length: mostly none, some short, now and then a long one.
   function automatic int idle_length(input bit enabled);
      int roll;
      if (!enabled)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 72)
         return 0;
      if (roll < 97)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic bl_item_type tick_item();
      // level and power are don't-care on a tick, so they carry noise
      return '{bls_pkg::OPC_TICK, bls_pkg::LEVEL_WIDTH'($urandom_range(0, 255)),
               1'($urandom_range(0, 1))};
   endfunction

   function automatic bl_item_type brightness(input logic [7:0] lvl, input logic pwr);
      return '{bls_pkg::OPC_REQUEST, lvl, pwr};
   endfunction

   // ----------------------------------------------------------------------
   // Receiver: random stalls in stretches, plus the long hold-off on demand.
   // Ready always goes back high after a stall.
   // ----------------------------------------------------------------------
   initial begin : rsp_ready_drive
      int low_cycles;
      int stretch;
      bit stalls_on;
      rsp_bus.ready = 1'b0;
      stretch       = 0;
      stalls_on     = 1'b1;
      forever begin
         @(posedge clock);
         if (stretch == 0) begin
            stalls_on = ($urandom_range(0, 2) != 0);
            stretch   = $urandom_range(100, 3000);
         end
         stretch--;
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            low_cycles       = HOLD_OFF_CYCLES;
         end else begin
            low_cycles = idle_length(stalls_on);
         end
         if (low_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (low_cycles) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   // Every rsp transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_line(rsp_bus.line_out, rsp_bus.busy_res, rsp_bus.accepted);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("one_wire_backlight_level_sender verification failed");
         $finish;
      end
   end

   // ----------------------------------------------------------------------
   // Sender tasks
   // ----------------------------------------------------------------------

   // Offers one item and returns at the edge of its transfer, with valid
   // still high so a following item can go out back to back.
   task automatic push_item(input bl_item_type item);
      int gap;
      if (src_stretch == 0) begin
         src_gaps_on = ($urandom_range(0, 2) != 0);
         src_stretch = $urandom_range(50, 2000);
      end
      src_stretch--;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         gap = idle_length(src_gaps_on);
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.opcode   <= item.opcode;
      req_bus.level    <= item.level;
      req_bus.power_on <= item.power_on;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_input(item);
      items_sent++;
   endtask

   // Stops offering and waits until every predicted line state has come back.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both registers, back to back; only called after settle, nothing in flight.
   task automatic program_settings(input logic [7:0] cpu_val, input logic [7:0] addr_val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= bls_pkg::CSR_CYCLES_PER_US;
      csr_bus.data  <= cpu_val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      sb.write_setting(bls_pkg::CSR_CYCLES_PER_US, cpu_val);
      csr_bus.index <= bls_pkg::CSR_DEVICE_ADDRESS;
      csr_bus.data  <= addr_val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      sb.write_setting(bls_pkg::CSR_DEVICE_ADDRESS, addr_val);
      csr_bus.valid <= 1'b0;
   endtask

   // Ticks the sequencer along until idle, max_items or the run budget,
   // slipping in requests at reject_ppm per item; those all land while busy.
   task automatic run_busy(input int max_items, input int reject_ppm);
      int n;
      n = 0;
      while (!sb.is_idle() && n < max_items && items_sent < ITEM_BUDGET) begin
         if ($urandom_range(0, 999_999) < reject_ppm)
            push_item(brightness(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
         else
            push_item(tick_item());
         n++;
      end
   endtask

   // Long receiver hold-off while the sender keeps pushing: fills the queue
   // and the output register so req ready has to drop.
   task automatic press_output();
      hold_off_pending = 1'b1;
      burst_left       = HOLD_OFF_BURST;
   endtask

   // ----------------------------------------------------------------------
   // Stimulus
   // ----------------------------------------------------------------------
   initial begin : stimulus
      req_bus.valid    = 1'b0;
      req_bus.opcode   = bls_pkg::OPC_TICK;
      req_bus.level    = '0;
      req_bus.power_on = 1'b0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = bls_pkg::CSR_CYCLES_PER_US;
      csr_bus.data     = '0;
      reset            = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // idle: tick does nothing, power-off requests pull the line low
      push_item(tick_item());
      push_item(brightness(8'hFF, 1'b0));
      push_item(brightness(8'h00, 1'b0));
      push_item(tick_item());

      // mode flag is set out of reset: 255 saturates to 32 and goes straight
      // to the address byte; the start bit raises the line again
      push_item(brightness(8'hFF, 1'b1));
      push_item(brightness(8'h01, 1'b1));
      press_output();
      run_busy(BYTE_RUN_ITEMS, 2000);

      // zero cycles per us behaves as one, mid data byte
      settle();
      program_settings(8'd0, 8'h00);
      run_busy(30, 20_000);

      // slower prescaler for the rest of the run
      settle();
      program_settings(8'd3, 8'($urandom_range(0, 255)));
      press_output();
      run_busy(ITEM_BUDGET, 100_000);

      settle();
      if (sb.failures() == 0)
         $display("one_wire_backlight_level_sender verification clean");
      else
         $display("one_wire_backlight_level_sender verification failed");
      $finish;
   end

endmodule

// File: sim.f
hdl/bls_pkg.sv
hdl/bls_req_if.sv
hdl/bls_rsp_if.sv
hdl/bls_csr_if.sv
hdl/bls_front.sv
hdl/bls_queue.sv
hdl/bls_back.sv
hdl/one_wire_backlight_level_sender.sv
verif/tb_top.sv
